[sv/kstef_pkg.sv]
package kstef_pkg;

   localparam int KSTEF_MAX_VERTICES = 256;

   localparam int VERTEX_W = 8;
   localparam int LABEL_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int WEIGHT_W = 32;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 9'd256;
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_MIN   = 9'd2;

   // one vertex slot as it travels around the ring
   typedef struct packed {
      logic               visited;
      logic [LABEL_W-1:0] label;
   } entry_type;

endpackage

[sv/kstef_cell.sv]
module kstef_cell
   import kstef_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type prev_entry,
   output entry_type entry
);

   logic               visited_ff;
   logic [LABEL_W-1:0] label_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= 1'b0;
      end else if (shift_en) begin
         visited_ff <= prev_entry.visited;
      end
   end

   // label is only meaningful while the slot is marked visited
   always_ff @(posedge clock) begin
      if (shift_en) begin
         label_ff <= prev_entry.label;
      end
   end

   assign entry.visited = visited_ff;
   assign entry.label   = label_ff;

endmodule

[sv/kruskal_spanning_tree_edge_filter_core.sv]
// Kruskal spanning-tree edge filter.
// req_*: one edge per request, edges sorted by ascending weight. req_tuser set
//   clears the vertex marks and accepted count before that edge is judged.
// rsp_*: one response for every edge taken into the spanning forest: its weight and
//   its position among accepted edges; rsp_tlast marks the edge that completes the
//   tree (vertex_count-1 accepted). Rejected edges give no response.
// csr_*: writes vertex_count; write only while the core is idle. Reset value 256.
// Vertex state lives in a ring of cells, one per vertex, rotating one slot a cycle
// while a lookup or update rotation runs. An edge that passes the range/self-loop/
// count checks costs a full lookup rotation of the ring and a decide state; a clear
// failing the checks costs the lookup rotation only. An accepted edge adds an update
// rotation and a state to post the response. An edge failing the checks without a
// clear is dropped straight from idle, with no rotation.
// Reset clears every visited mark and the accepted count at once, no sweep.
// A response waits in the output register while rsp_tready is low; the next edge
// can still be taken and is processed, stalling only when its own response is due.
module kruskal_spanning_tree_edge_filter_core
   import kstef_pkg::*;
#(
   parameter int MAX_VERTICES = KSTEF_MAX_VERTICES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // first_vertex[7:0], second_vertex[15:8],
                                    // edge_weight[47:16]
   input  logic [0:0]   req_tuser,  // start_graph[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // tree_weight[31:0], tree_position[39:32]
   output logic         rsp_tlast,  // tree_complete
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [8:0]   csr_data    // vertex_count
);

   localparam int NCELLS = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
   localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
   localparam logic [CW-1:0]      STEP_LAST = CW'(NCELLS - 1);
   localparam logic [COUNT_W-1:0] N_MAX     = COUNT_W'(NCELLS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       step_ff, step_in;
   logic [COUNT_W-1:0]  vertex_count_ff;
   logic [COUNT_W-1:0]  n_ff, n_in;
   logic [VERTEX_W-1:0] count_ff, count_in;
   logic [VERTEX_W-1:0] a_ff, b_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                clr_ff, ok_ff, ok_in;
   logic                va_ff, vb_ff, va_in, vb_in;
   logic [LABEL_W-1:0]  la_ff, lb_ff, la_in, lb_in;
   logic                rsp_valid_ff;
   logic [WEIGHT_W-1:0] rsp_weight_ff;
   logic [VERTEX_W-1:0] rsp_pos_ff;
   logic                rsp_complete_ff;

   logic [VERTEX_W-1:0] req_a, req_b;
   logic [VERTEX_W-1:0] count_eff;
   logic                req_take, shift_en, rsp_load;
   logic [CW-1:0]       slot_idx;
   logic [VERTEX_W-1:0] slot_v;
   entry_type           ring [NCELLS];
   entry_type           head, wb;

   assign req_a      = req_tdata[7:0];
   assign req_b      = req_tdata[15:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign shift_en   = (state_ff == ST_READ) || (state_ff == ST_WRITE);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // ring of vertex cells; cell 0 takes the updated head slot
   for (genvar k = 0; k < NCELLS; k++) begin : g_cell
      kstef_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .prev_entry ((k == 0) ? wb : ring[(k == 0) ? 0 : k - 1]),
         .entry      (ring[k])
      );
   end

   // full rotations keep alignment: slot leaving the last cell at step s is vertex NCELLS-1-s
   assign head     = ring[NCELLS-1];
   assign slot_idx = STEP_LAST - step_ff;
   assign slot_v   = VERTEX_W'(slot_idx);

   always_comb begin
      wb = head;
      if (state_ff == ST_READ) begin
         if (clr_ff) begin
            wb.visited = 1'b0;
         end
      end else if (state_ff == ST_WRITE) begin
         case ({va_ff, vb_ff})
            2'b11: begin
               if (({1'b0, slot_v} < n_ff) && head.visited && (head.label == la_ff)) begin
                  wb.label = lb_ff;
               end
            end
            2'b10: begin
               if (slot_v == b_ff) begin
                  wb.visited = 1'b1;
                  wb.label   = la_ff;
               end
            end
            2'b01: begin
               if (slot_v == a_ff) begin
                  wb.visited = 1'b1;
                  wb.label   = lb_ff;
               end
            end
            default: begin
               if ((slot_v == a_ff) || (slot_v == b_ff)) begin
                  wb.visited = 1'b1;
                  wb.label   = b_ff;
               end
            end
         endcase
      end
   end

   always_comb begin
      n_in = vertex_count_ff;
      if (vertex_count_ff < VERTEX_COUNT_MIN) begin
         n_in = VERTEX_COUNT_MIN;
      end else if (vertex_count_ff > N_MAX) begin
         n_in = N_MAX;
      end
   end

   assign count_eff = req_tuser[0] ? '0 : count_ff;
   assign ok_in = ({1'b0, count_eff} < (n_in - 9'd1)) && ({1'b0, req_a} < n_in) &&
                  ({1'b0, req_b} < n_in) && (req_a != req_b);

   // lookup captures during the read rotation
   always_comb begin
      va_in = va_ff;
      vb_in = vb_ff;
      la_in = la_ff;
      lb_in = lb_ff;
      if (state_ff == ST_READ) begin
         if (slot_v == a_ff) begin
            va_in = wb.visited;
            la_in = wb.label;
         end
         if (slot_v == b_ff) begin
            vb_in = wb.visited;
            lb_in = wb.label;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser[0]) begin
                  count_in = '0;
               end
               if (ok_in || req_tuser[0]) begin
                  state_in = ST_READ;
                  step_in  = '0;
               end
            end
         end
         ST_READ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ok_ff ? ST_DECIDE : ST_IDLE;
            end
         end
         ST_DECIDE: begin
            if (va_ff && vb_ff && (la_ff == lb_ff)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WRITE;
               step_in  = '0;
            end
         end
         ST_WRITE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         count_ff        <= '0;
         vertex_count_ff <= VERTEX_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            vertex_count_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_ff      <= req_a;
         b_ff      <= req_b;
         weight_ff <= req_tdata[47:16];
         clr_ff    <= req_tuser[0];
         ok_ff     <= ok_in;
         n_ff      <= n_in;
      end
      va_ff <= va_in;
      vb_ff <= vb_in;
      la_ff <= la_in;
      lb_ff <= lb_in;
      if (rsp_load) begin
         rsp_weight_ff   <= weight_ff;
         rsp_pos_ff      <= count_ff;
         rsp_complete_ff <= (({1'b0, count_ff} + 9'd1) == (n_ff - 9'd1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_weight_ff};
   assign rsp_tlast  = rsp_complete_ff;

   // an accepted edge never pushes the count past n-1
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ({1'b0, count_ff} < (n_ff - 9'd1)))
      else $error("accepted count overruns tree size");

   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ok_ff)
      else $error("response pending for an edge that failed the checks");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   // after a clear both endpoints must read back unvisited
   a_clear_lookup: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DECIDE) && clr_ff) |-> (!va_ff && !vb_ff))
      else $error("cleared graph still shows a visited endpoint");

endmodule
